>>> sv/hbu_pkg.sv
// Shared types and constants for the heightmap bilinear patch upscaler.
`timescale 1ns / 1ps
package hbu_pkg;

	localparam int CNT_W   = 3;
	localparam int SHIFT_W = 2;
	localparam int WGT_W   = CNT_W + 1;
	localparam int OUT_H_W = 16;

	typedef enum logic [1:0] {
		MODE_INTERIOR = 2'd0,
		MODE_COLUMN   = 2'd1,
		MODE_ROW      = 2'd2,
		MODE_CORNER   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CNT_W-1:0]   row;
		logic [CNT_W-1:0]   col;
		logic [SHIFT_W-1:0] sh;
		logic               last;
	} ctl_t;

endpackage

>>> sv/heightmap_bilinear_patch_upscaler_top.sv
// Top level of the heightmap bilinear patch upscaler.
//
// Input channel (in_valid/in_ready): one coarse cell per transfer, with mode and
// four corner heights. Output channel (out_valid/out_ready): one fine sample per
// transfer with height, patch_row, patch_col and last on the final sample.
// Interior cells give M*M samples, edge cells M, the corner cell one; M is
// 2^scale_shift, written through cfg_we/cfg_wdata (0 reads as 1, values above
// MAX_SCALE_SHIFT are clamped) and sampled when a cell is taken.
// Throughput: one sample per cycle while out_ready is high, set by the row/column
// sequencer. The next cell is taken in the cycle its predecessor's last sample
// enters the pipeline, so cells stream with no gap.
// After its transfer, the first sample of a cell passes two multiply stages and
// the output register behind the sequencer.
// A stalled receiver holds each stage in place; nothing is lost or repeated.
// Reset clears all valid bits and sets scale_shift to 1.
`timescale 1ns / 1ps
module heightmap_bilinear_patch_upscaler_top #(
	parameter int MAX_SCALE_SHIFT = 3,
	parameter int HEIGHT_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hbu_pkg::SHIFT_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [hbu_pkg::OUT_H_W-1:0]   top_left,
	input  logic [hbu_pkg::OUT_H_W-1:0]   top_right,
	input  logic [hbu_pkg::OUT_H_W-1:0]   bottom_left,
	input  logic [hbu_pkg::OUT_H_W-1:0]   bottom_right,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hbu_pkg::OUT_H_W-1:0]   height,
	output logic [hbu_pkg::CNT_W-1:0]     patch_row,
	output logic [hbu_pkg::CNT_W-1:0]     patch_col,
	output logic                          last
);
	import hbu_pkg::*;

	logic                   seq_valid;
	logic                   pipe_ready;
	ctl_t                   seq_ctl;
	logic [HEIGHT_BITS-1:0] c_tl, c_tr, c_bl, c_br;

	hbu_seq #(
		.MAX_SCALE_SHIFT(MAX_SCALE_SHIFT),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.top_left(top_left),
		.top_right(top_right),
		.bottom_left(bottom_left),
		.bottom_right(bottom_right),
		.out_valid(seq_valid),
		.out_ready(pipe_ready),
		.ctl(seq_ctl),
		.c_tl(c_tl),
		.c_tr(c_tr),
		.c_bl(c_bl),
		.c_br(c_br)
	);

	hbu_pipe #(
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(seq_valid),
		.in_ready(pipe_ready),
		.ctl(seq_ctl),
		.c_tl(c_tl),
		.c_tr(c_tr),
		.c_bl(c_bl),
		.c_br(c_br),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.height(height),
		.patch_row(patch_row),
		.patch_col(patch_col),
		.last(last)
	);

	a_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> seq_valid && seq_ctl.row == '0 && seq_ctl.col == '0)
		else $error("cell did not start at patch origin");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid && pipe_ready && !seq_ctl.last |=> seq_valid)
		else $error("sample run ended before last");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> seq_valid && !(pipe_ready && seq_ctl.last))
		else $error("input stalled while sequencer free");

endmodule

>>> sv/hbu_seq.sv
// Sample sequencer: holds one cell, steps the fine row/column offsets one per cycle while out_ready is high.
`timescale 1ns / 1ps
module hbu_seq #(
	parameter int MAX_SCALE_SHIFT = 3,
	parameter int HEIGHT_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hbu_pkg::SHIFT_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [hbu_pkg::OUT_H_W-1:0]   top_left,
	input  logic [hbu_pkg::OUT_H_W-1:0]   top_right,
	input  logic [hbu_pkg::OUT_H_W-1:0]   bottom_left,
	input  logic [hbu_pkg::OUT_H_W-1:0]   bottom_right,
	output logic                          out_valid,
	input  logic                          out_ready,
	output hbu_pkg::ctl_t                 ctl,
	output logic [HEIGHT_BITS-1:0]        c_tl,
	output logic [HEIGHT_BITS-1:0]        c_tr,
	output logic [HEIGHT_BITS-1:0]        c_bl,
	output logic [HEIGHT_BITS-1:0]        c_br
);
	import hbu_pkg::*;

	localparam logic [SHIFT_W-1:0] MAX_SH = SHIFT_W'(MAX_SCALE_SHIFT);

	logic [SHIFT_W-1:0] scale_shift_q;
	logic [SHIFT_W-1:0] eff_sh;
	logic [SHIFT_W-1:0] sh_q;
	mode_t              mode_q;
	logic [CNT_W-1:0]   row_q;
	logic [CNT_W-1:0]   col_q;
	logic               busy_q;
	logic [CNT_W-1:0]   m_last;
	logic               last;
	logic               accept;
	logic               step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_shift_q <= SHIFT_W'(1);
		end else if (cfg_we) begin
			scale_shift_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (scale_shift_q == '0) begin
			eff_sh = SHIFT_W'(1);
		end else if (scale_shift_q > MAX_SH) begin
			eff_sh = MAX_SH;
		end else begin
			eff_sh = scale_shift_q;
		end
	end

	assign m_last = CNT_W'((WGT_W'(1) << sh_q) - WGT_W'(1));

	always_comb begin
		unique case (mode_q)
			MODE_INTERIOR: last = (row_q == m_last) && (col_q == m_last);
			MODE_COLUMN:   last = (row_q == m_last);
			MODE_ROW:      last = (col_q == m_last);
			default:       last = 1'b1;
		endcase
	end

	assign out_valid = busy_q;
	assign step      = busy_q && out_ready;
	assign in_ready  = !busy_q || (out_ready && last);
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
			mode_q <= MODE_INTERIOR;
			sh_q   <= SHIFT_W'(1);
		end else if (accept) begin
			busy_q <= 1'b1;
			row_q  <= '0;
			col_q  <= '0;
			mode_q <= mode_t'(mode);
			sh_q   <= eff_sh;
		end else if (step) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				unique case (mode_q)
					MODE_INTERIOR: begin
						if (col_q == m_last) begin
							col_q <= '0;
							row_q <= row_q + CNT_W'(1);
						end else begin
							col_q <= col_q + CNT_W'(1);
						end
					end
					MODE_COLUMN: row_q <= row_q + CNT_W'(1);
					MODE_ROW:    col_q <= col_q + CNT_W'(1);
					default:     row_q <= row_q;
				endcase
			end
		end
	end

	// corner payload, loaded on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			c_tl <= top_left[HEIGHT_BITS-1:0];
			c_tr <= top_right[HEIGHT_BITS-1:0];
			c_bl <= bottom_left[HEIGHT_BITS-1:0];
			c_br <= bottom_right[HEIGHT_BITS-1:0];
		end
	end

	assign ctl.row  = row_q;
	assign ctl.col  = col_q;
	assign ctl.sh   = sh_q;
	assign ctl.last = last;

endmodule

>>> sv/hbu_pipe.sv
// Interpolation pipeline: horizontal lerp, vertical lerp, floor shift and output register.
`timescale 1ns / 1ps
module hbu_pipe #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hbu_pkg::ctl_t                 ctl,
	input  logic [HEIGHT_BITS-1:0]        c_tl,
	input  logic [HEIGHT_BITS-1:0]        c_tr,
	input  logic [HEIGHT_BITS-1:0]        c_bl,
	input  logic [HEIGHT_BITS-1:0]        c_br,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hbu_pkg::OUT_H_W-1:0]   height,
	output logic [hbu_pkg::CNT_W-1:0]     patch_row,
	output logic [hbu_pkg::CNT_W-1:0]     patch_col,
	output logic                          last
);
	import hbu_pkg::*;

	localparam int TW = HEIGHT_BITS + CNT_W;
	localparam int SW = HEIGHT_BITS + 2 * CNT_W;

	logic                   v_s2, v_s3, v_s4;
	ctl_t                   ctl_s2, ctl_s3, ctl_s4;
	logic [TW-1:0]          top_s2, bot_s2;
	logic [SW-1:0]          sum_s3;
	logic [HEIGHT_BITS-1:0] h_s4;
	logic                   adv2, adv3, adv4;
	logic [WGT_W-1:0]       m_in, wc, m_s2, wr;
	logic [TW-1:0]          top_d, bot_d;
	logic [SW-1:0]          sum_d;
	logic [SW-1:0]          shifted;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign in_ready = adv2;

	assign m_in  = WGT_W'(1) << ctl.sh;
	assign wc    = m_in - WGT_W'(ctl.col);
	assign top_d = TW'(c_tl) * TW'(wc) + TW'(c_tr) * TW'(ctl.col);
	assign bot_d = TW'(c_bl) * TW'(wc) + TW'(c_br) * TW'(ctl.col);

	assign m_s2  = WGT_W'(1) << ctl_s2.sh;
	assign wr    = m_s2 - WGT_W'(ctl_s2.row);
	assign sum_d = SW'(top_s2) * SW'(wr) + SW'(bot_s2) * SW'(ctl_s2.row);

	assign shifted = sum_s3 >> {ctl_s3.sh, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv2) v_s2 <= in_valid;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ctl_s2 <= ctl;
			top_s2 <= top_d;
			bot_s2 <= bot_d;
		end
		if (adv3) begin
			ctl_s3 <= ctl_s2;
			sum_s3 <= sum_d;
		end
		if (adv4) begin
			ctl_s4 <= ctl_s3;
			h_s4   <= shifted[HEIGHT_BITS-1:0];
		end
	end

	assign out_valid = v_s4;
	assign height    = OUT_H_W'(h_s4);
	assign patch_row = ctl_s4.row;
	assign patch_col = ctl_s4.col;
	assign last      = ctl_s4.last;

endmodule

>>> tb/sv/heightmap_bilinear_patch_upscaler_top_tb.sv
// Self-checking testbench for the heightmap bilinear patch upscaler top level.
`timescale 1ns / 1ps
module heightmap_bilinear_patch_upscaler_top_tb;
	import hbu_pkg::*;

	localparam int MAX_SHIFT   = 3;
	localparam int STALL_LIMIT = 1000;
	localparam int SEG_CELLS   = 32;
	localparam int SEGMENTS    = 6;

	typedef struct {
		logic [OUT_H_W-1:0] height;
		logic [CNT_W-1:0]   row;
		logic [CNT_W-1:0]   col;
		logic               last;
	} fine_sample_t;

	class patch_scoreboard;
		fine_sample_t       pending_samples[$];
		logic [SHIFT_W-1:0] scale_reg = SHIFT_W'(1);
		int                 cells   = 0;
		int                 samples = 0;
		int                 errors  = 0;

		function void push(logic [63:0] h, int r, int c, bit l);
			fine_sample_t s;
			s.height = h[OUT_H_W-1:0];
			s.row    = r[CNT_W-1:0];
			s.col    = c[CNT_W-1:0];
			s.last   = l;
			pending_samples.push_back(s);
		endfunction

		function int pending();
			return pending_samples.size();
		endfunction

		// Expected fine samples of one coarse cell, with the shift clamped to 1..MAX_SHIFT.
		function void note_cell(mode_t m, logic [OUT_H_W-1:0] tl, logic [OUT_H_W-1:0] tr,
				logic [OUT_H_W-1:0] bl, logic [OUT_H_W-1:0] br);
			int          sh;
			int          fine;
			int          r;
			int          c;
			logic [63:0] top;
			logic [63:0] bot;
			logic [63:0] acc;
			sh = (scale_reg == 0) ? 1 : ((int'(scale_reg) > MAX_SHIFT) ? MAX_SHIFT : scale_reg);
			fine = 1 << sh;
			cells++;
			case (m)
			MODE_INTERIOR: begin
				for (r = 0; r < fine; r++)
					for (c = 0; c < fine; c++) begin
						top = 64'(tl) * 64'(fine - c) + 64'(tr) * 64'(c);
						bot = 64'(bl) * 64'(fine - c) + 64'(br) * 64'(c);
						acc = top * 64'(fine - r) + bot * 64'(r);
						push(acc >> (2 * sh), r, c, (r == fine - 1) && (c == fine - 1));
					end
			end
			MODE_COLUMN: begin
				for (r = 0; r < fine; r++) begin
					acc = 64'(tl) * 64'(fine - r) + 64'(bl) * 64'(r);
					push(acc >> sh, r, 0, r == fine - 1);
				end
			end
			MODE_ROW: begin
				for (c = 0; c < fine; c++) begin
					acc = 64'(tl) * 64'(fine - c) + 64'(tr) * 64'(c);
					push(acc >> sh, 0, c, c == fine - 1);
				end
			end
			default: push(64'(tl), 0, 0, 1'b1);
			endcase
		endfunction

		function void check_sample(fine_sample_t got);
			fine_sample_t want;
			samples++;
			if (pending_samples.size() == 0) begin
				$error("unexpected sample: height %0d row %0d col %0d last %0b",
					got.height, got.row, got.col, got.last);
				errors++;
				return;
			end
			want = pending_samples.pop_front();
			if (got.height !== want.height) begin
				$error("height: expected %0d, got %0d", want.height, got.height);
				errors++;
			end
			if (got.row !== want.row) begin
				$error("patch_row: expected %0d, got %0d", want.row, got.row);
				errors++;
			end
			if (got.col !== want.col) begin
				$error("patch_col: expected %0d, got %0d", want.col, got.col);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [SHIFT_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [OUT_H_W-1:0] top_left;
	logic [OUT_H_W-1:0] top_right;
	logic [OUT_H_W-1:0] bottom_left;
	logic [OUT_H_W-1:0] bottom_right;
	logic               out_valid;
	logic               out_ready;
	logic [OUT_H_W-1:0] height;
	logic [CNT_W-1:0]   patch_row;
	logic [CNT_W-1:0]   patch_col;
	logic               last;

	patch_scoreboard board = new();
	fine_sample_t    seen;
	int              quiet_cycles = 0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              send_idle_by_phase[3] = '{7, 72, 0};
	int              recv_idle_by_phase[3] = '{72, 7, 0};
	int              scale_by_segment[SEGMENTS] = '{1, 3, 2, 0, 3, 1};

	heightmap_bilinear_patch_upscaler_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.height       (height),
		.patch_row    (patch_row),
		.patch_col    (patch_col),
		.last         (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// transfer monitor, scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_cell(mode_t'(mode), top_left, top_right, bottom_left, bottom_right);
			if (out_valid && out_ready) begin
				seen.height = height;
				seen.row    = patch_row;
				seen.col    = patch_col;
				seen.last   = last;
				board.check_sample(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [OUT_H_W-1:0] rand_height();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return OUT_H_W'($urandom_range(0, 15));
		3: return 16'hfff0 | OUT_H_W'($urandom_range(0, 15));
		default: return OUT_H_W'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_cell(input mode_t m, input logic [OUT_H_W-1:0] tl,
			input logic [OUT_H_W-1:0] tr, input logic [OUT_H_W-1:0] bl,
			input logic [OUT_H_W-1:0] br);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		top_left     <= tl;
		top_right    <= tr;
		bottom_left  <= bl;
		bottom_right <= br;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_cells();
		in_valid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	task automatic set_scale(input logic [SHIFT_W-1:0] v);
		drain_cells();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		board.scale_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_cells();
		send_cell(MODE_INTERIOR, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
		send_cell(MODE_INTERIOR, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_cell(MODE_INTERIOR, 16'h0001, 16'h0002, 16'h0003, 16'h8000);
		send_cell(MODE_COLUMN,   16'h0000, 16'hffff, 16'hffff, 16'hffff);
		send_cell(MODE_COLUMN,   16'hffff, 16'h0000, 16'h0000, 16'h0000);
		send_cell(MODE_ROW,      16'hffff, 16'h0000, 16'hffff, 16'hffff);
		send_cell(MODE_CORNER,   16'hffff, 16'h0000, 16'h1234, 16'h5678);
	endtask

	initial begin
		int seg;
		int n;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		mode         = MODE_INTERIOR;
		top_left     = '0;
		top_right    = '0;
		bottom_left  = '0;
		bottom_right = '0;
		out_ready    = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset scale, then shift 0 (saturates to 1), then the largest shift
		directed_cells();
		set_scale(SHIFT_W'(0));
		directed_cells();
		set_scale(SHIFT_W'(3));
		directed_cells();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			send_idle_pct = send_idle_by_phase[seg / 2];
			recv_idle_pct = recv_idle_by_phase[seg / 2];
			set_scale(SHIFT_W'(scale_by_segment[seg]));
			for (n = 0; n < SEG_CELLS; n++) begin
				if ($urandom_range(0, 29) == 0)
					drain_cells();
				send_cell(mode_t'($urandom_range(0, 3)), rand_height(), rand_height(),
					rand_height(), rand_height());
			end
		end

		drain_cells();
		repeat (20) @(negedge clk);
		$display("Run covered %0d cells and %0d fine samples in all four modes,",
			board.cells, board.samples);
		$display("scale settings 0 to 3, and three stall mixes on both channels.");
		if (board.errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
